@@ sv/ssf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssf_pkg: stick snapback filter shared definitions
// Field widths, configuration register map, reset values and helpers.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 14;
  localparam int OFF_W      = 15;
  localparam int DIST_W     = 14;
  localparam int CNT_W      = 8;
  localparam int DCFG_W     = 13;
  localparam int US_W       = 20;

  localparam logic [1:0] FALL_RUN_LIMIT = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER,
    CFG_STICK_RANGE,
    CFG_SNAPBACK_DIST,
    CFG_CROSSING_DIST,
    CFG_CENTERED_DIST,
    CFG_WAVE_DURATION,
    CFG_WAVE_BUFFER,
    CFG_ELIG_TIMEOUT
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]  center;
    logic [CNT_W-1:0]  stick_range;
    logic [DCFG_W-1:0] snap_thresh;
    logic [DCFG_W-1:0] cross_limit;
    logic [DCFG_W-1:0] fall_floor;
    logic [US_W-1:0]   wave_duration_us;
    logic [US_W-1:0]   wave_buffer_us;
    logic [US_W-1:0]   eligibility_timeout_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center:                 8'd128,
    stick_range:            8'd100,
    snap_thresh:            13'd1120,
    cross_limit:            13'd480,
    fall_floor:             13'd48,
    wave_duration_us:       20'd50000,
    wave_buffer_us:         20'd2000,
    eligibility_timeout_us: 20'd100000
  };

  typedef struct packed {
    logic [CNT_W-1:0] counts;
    logic             held;
  } axis_res_t;

  function automatic logic [DIST_W-1:0] offset_mag(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] n;
    n = -v;
    return v[OFF_W-1] ? n[DIST_W-1:0] : v[DIST_W-1:0];
  endfunction

endpackage

@@ sv/ssf_in_if.sv @@
// ----------------------------------------------------------------------------
// ssf_in_if: stick sample channel
// Valid/ready channel carrying one two-axis stick sample per beat.
// ----------------------------------------------------------------------------
interface ssf_in_if;
  import ssf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     fresh;
  logic signed [POS_W-1:0]  norm_x;
  logic signed [POS_W-1:0]  norm_y;
  logic [TIME_W-1:0]        time_us;

  modport source (output valid, fresh, norm_x, norm_y, time_us, input ready);
  modport sink   (input valid, fresh, norm_x, norm_y, time_us, output ready);
endinterface

@@ sv/ssf_out_if.sv @@
// ----------------------------------------------------------------------------
// ssf_out_if: filtered stick result channel
// Valid/ready channel carrying one filtered two-axis result per beat.
// ----------------------------------------------------------------------------
interface ssf_out_if;
  import ssf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] out_x;
  logic [CNT_W-1:0] out_y;
  logic             x_held;
  logic             y_held;

  modport source (output valid, out_x, out_y, x_held, y_held, input ready);
  modport sink   (input valid, out_x, out_y, x_held, y_held, output ready);
endinterface

@@ sv/ssf_axis.sv @@
// ----------------------------------------------------------------------------
// ssf_axis: per-axis snapback state and output conversion
// Eligibility, center-crossing hold, falling detection and count clamping
// for one axis. State advances on upd; res shows the post-update values.
// ----------------------------------------------------------------------------
module ssf_axis (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd,
  input  ssf_pkg::cfg_t                    cfg,
  input  logic signed [ssf_pkg::POS_W-1:0] pos,
  input  logic signed [ssf_pkg::OFF_W-1:0] off,
  input  logic [ssf_pkg::DIST_W-1:0]       own_dist,
  input  logic [ssf_pkg::DIST_W-1:0]       other_dist,
  input  logic [ssf_pkg::TIME_W-1:0]       now,
  output ssf_pkg::axis_res_t               res
);
  import ssf_pkg::*;

  logic                    elig_r, elig_nxt;
  logic [TIME_W-1:0]       etime_r, etime_nxt;
  logic                    etime_set_r, etime_set_nxt;
  logic                    hold_r, hold_nxt;
  logic                    fall_r, fall_nxt;
  logic [1:0]              run_r, run_nxt;
  logic [TIME_W-1:0]       wstart_r, wstart_nxt;
  logic [TIME_W-1:0]       wend_r, wend_nxt;
  logic signed [OFF_W-1:0] last_off_r, last_off_nxt;
  logic [CNT_W-1:0]        last_out_r, last_out_nxt;

  logic [TIME_W-1:0] d_elig, d_wend, elapsed, wend_fall;
  logic [DIST_W-1:0] last_dist;
  logic              crossed, falling_smp;
  logic [1:0]        run_inc;

  logic signed [OFF_W-1:0] c16, lo, hi, v, vr, r;
  logic signed [9:0]       lo_c;
  logic [8:0]              hi_c;
  logic [CNT_W-1:0]        counts;

  assign d_elig      = now - etime_r;
  assign d_wend      = now - wend_r;
  assign elapsed     = now - wstart_r;
  assign wend_fall   = now + elapsed + {{(TIME_W-US_W){1'b0}}, cfg.wave_buffer_us};
  assign last_dist   = offset_mag(last_off_r);
  assign crossed     = (off[OFF_W-1] != last_off_r[OFF_W-1]) &&
                       (other_dist <= {1'b0, cfg.cross_limit});
  assign falling_smp = (own_dist <= last_dist) && (own_dist >= {1'b0, cfg.fall_floor});
  assign run_inc     = falling_smp ? run_r + 2'd1 : 2'd0;

  always_comb begin
    elig_nxt      = elig_r;
    etime_nxt     = etime_r;
    etime_set_nxt = etime_set_r;
    hold_nxt      = hold_r;
    fall_nxt      = fall_r;
    run_nxt       = run_r;
    wstart_nxt    = wstart_r;
    wend_nxt      = wend_r;
    last_off_nxt  = last_off_r;
    if (upd) begin
      if (own_dist >= {1'b0, cfg.snap_thresh}) begin
        elig_nxt      = 1'b1;
        etime_nxt     = now;
        etime_set_nxt = 1'b1;
      end else if (etime_set_r && !d_elig[TIME_W-1] &&
                   d_elig >= {{(TIME_W-US_W){1'b0}}, cfg.eligibility_timeout_us}) begin
        elig_nxt      = 1'b0;
        etime_set_nxt = 1'b0;
      end

      if (elig_nxt && crossed) begin
        fall_nxt   = 1'b0;
        run_nxt    = 2'd0;
        wstart_nxt = now;
        wend_nxt   = now + {{(TIME_W-US_W){1'b0}}, cfg.wave_duration_us};
        hold_nxt   = 1'b1;
        elig_nxt   = 1'b0;
      end else if (hold_r) begin
        if (!d_wend[TIME_W-1]) begin
          hold_nxt = 1'b0;
          elig_nxt = 1'b0;
        end else if (!fall_r) begin
          if (run_inc == FALL_RUN_LIMIT) begin
            fall_nxt = 1'b1;
            run_nxt  = 2'd0;
            wend_nxt = wend_fall;
          end else begin
            run_nxt = run_inc;
          end
        end
      end
      last_off_nxt = off;
    end
  end

  // clamp to center +/- range, round half up, saturate
  always_comb begin
    c16  = $signed({3'b000, cfg.center, 4'b0000});
    lo_c = $signed({2'b00, cfg.center}) - $signed({2'b00, cfg.stick_range});
    hi_c = {1'b0, cfg.center} + {1'b0, cfg.stick_range};
    lo   = $signed({lo_c[9], lo_c, 4'b0000});
    hi   = $signed({2'b00, hi_c, 4'b0000});
    v    = hold_nxt ? c16 : $signed({pos[POS_W-1], pos});
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    vr = v + 15'sd8;
    r  = vr >>> 4;
    if (r < 15'sd0) begin
      counts = '0;
    end else if (r > 15'sd255) begin
      counts = '1;
    end else begin
      counts = r[CNT_W-1:0];
    end
  end

  assign last_out_nxt = upd ? counts : last_out_r;
  assign res.counts   = last_out_nxt;
  assign res.held     = hold_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elig_r      <= 1'b0;
      etime_r     <= '0;
      etime_set_r <= 1'b0;
      hold_r      <= 1'b0;
      fall_r      <= 1'b0;
      run_r       <= 2'd0;
      wstart_r    <= '0;
      wend_r      <= '0;
      last_off_r  <= '0;
      last_out_r  <= '0;
    end else begin
      elig_r      <= elig_nxt;
      etime_r     <= etime_nxt;
      etime_set_r <= etime_set_nxt;
      hold_r      <= hold_nxt;
      fall_r      <= fall_nxt;
      run_r       <= run_nxt;
      wstart_r    <= wstart_nxt;
      wend_r      <= wend_nxt;
      last_off_r  <= last_off_nxt;
      last_out_r  <= last_out_nxt;
    end
  end

endmodule

@@ sv/stick_snapback_filter_top.sv @@
// ----------------------------------------------------------------------------
// stick_snapback_filter_top: two-axis stick snapback filter
//
// in_ch takes one stick sample per beat (fresh flag, Q10.4 x/y, microsecond
// timestamp). out_ch returns one result per sample: x/y in counts and a
// held flag per axis. A stale sample repeats the previous counts.
// cfg_we/cfg_idx/cfg_wdata write the eight settings; write only while idle.
//
// An input beat goes to the input register, then to the result register.
// Throughput: one sample per cycle while out_ch does not stall. The per-axis
// state update is combinational between the input register and the result
// register, so the next sample uses the state left by the previous one directly.
// A result waiting on a stalled out_ch does not block one more input beat;
// in_ch.ready drops only when both registers are full.
// Reset (synchronous, rst_n low) clears all axis state and both valid flags
// and loads the default settings.
// ----------------------------------------------------------------------------
module stick_snapback_filter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ssf_in_if.sink                          in_ch,
  ssf_out_if.source                       out_ch
);
  import ssf_pkg::*;

  cfg_t cfg_r;

  logic                    s1_valid_r;
  logic                    s1_fresh_r;
  logic signed [POS_W-1:0] s1_x_r, s1_y_r;
  logic [TIME_W-1:0]       s1_time_r;

  logic                    out_valid_r;
  axis_res_t               res_x_r, res_y_r;
  axis_res_t               res_x, res_y;

  logic                    in_acc, adv, upd;
  logic signed [OFF_W-1:0] off_x, off_y, c16;
  logic [DIST_W-1:0]       dist_x, dist_y;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign upd          = adv && s1_fresh_r;

  assign c16    = $signed({3'b000, cfg_r.center, 4'b0000});
  assign off_x  = $signed({s1_x_r[POS_W-1], s1_x_r}) - c16;
  assign off_y  = $signed({s1_y_r[POS_W-1], s1_y_r}) - c16;
  assign dist_x = offset_mag(off_x);
  assign dist_y = offset_mag(off_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_CENTER:        cfg_r.center                 <= cfg_wdata[CNT_W-1:0];
        CFG_STICK_RANGE:   cfg_r.stick_range            <= cfg_wdata[CNT_W-1:0];
        CFG_SNAPBACK_DIST: cfg_r.snap_thresh            <= cfg_wdata[DCFG_W-1:0];
        CFG_CROSSING_DIST: cfg_r.cross_limit            <= cfg_wdata[DCFG_W-1:0];
        CFG_CENTERED_DIST: cfg_r.fall_floor             <= cfg_wdata[DCFG_W-1:0];
        CFG_WAVE_DURATION: cfg_r.wave_duration_us       <= cfg_wdata[US_W-1:0];
        CFG_WAVE_BUFFER:   cfg_r.wave_buffer_us         <= cfg_wdata[US_W-1:0];
        CFG_ELIG_TIMEOUT:  cfg_r.eligibility_timeout_us <= cfg_wdata[US_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fresh_r <= in_ch.fresh;
      s1_x_r     <= in_ch.norm_x;
      s1_y_r     <= in_ch.norm_y;
      s1_time_r  <= in_ch.time_us;
    end
  end

  ssf_axis u_axis_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .cfg        (cfg_r),
    .pos        (s1_x_r),
    .off        (off_x),
    .own_dist   (dist_x),
    .other_dist (dist_y),
    .now        (s1_time_r),
    .res        (res_x)
  );

  ssf_axis u_axis_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .cfg        (cfg_r),
    .pos        (s1_y_r),
    .off        (off_y),
    .own_dist   (dist_y),
    .other_dist (dist_x),
    .now        (s1_time_r),
    .res        (res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_x_r <= res_x;
      res_y_r <= res_y;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = res_x_r.counts;
  assign out_ch.out_y  = res_y_r.counts;
  assign out_ch.x_held = res_x_r.held;
  assign out_ch.y_held = res_y_r.held;

  // a held axis on a fresh beat reports exactly the center
  a_x_held_center: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> (!out_ch.x_held || out_ch.out_x == $past(cfg_r.center)))
    else $error("x held but not at center");

  a_y_held_center: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> (!out_ch.y_held || out_ch.out_y == $past(cfg_r.center)))
    else $error("y held but not at center");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a staged sample");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stick snapback filter testbench
// Drives stick samples through the valid/ready input channel and scores each
// result beat against a cycle-free model of the filter kept in this file:
// eligibility, center-crossing holds, hold shortening on falling samples,
// clamping, rounding and saturation. A directed part covers rounding, stale
// samples, a full hold cycle, the zero-offset crossing, timestamp wrap and
// saturation at the settings extremes. Random stick gestures under several
// settings follow, with bursty input traffic and a stalling result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ssf_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] x;
    logic [CNT_W-1:0] y;
    logic             xh;
    logic             yh;
  } stick_result_t;

  typedef struct packed {
    bit                eligible;
    bit [TIME_W-1:0]   elig_time;
    bit                elig_time_valid;
    bit                in_hold;
    bit                falling;
    bit [1:0]          fall_run;
    bit [TIME_W-1:0]   wave_start;
    bit [TIME_W-1:0]   wave_end;
    logic signed [31:0] last_off;
    bit [CNT_W-1:0]    last_out;
  } axis_track_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ssf_in_if  in_ch ();
  ssf_out_if out_ch ();

  stick_snapback_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  axis_track_t     trk [2];
  cfg_t            cfg;
  stick_result_t   filtered_q [$];
  logic [TIME_W-1:0] now_us;
  int burst_left = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_held     = 0;
  int n_settings = 0;
  int n_errors   = 0;

  // --------------------------------------------------------------------------
  // filter model
  // --------------------------------------------------------------------------
  function automatic bit not_before(logic [TIME_W-1:0] from, logic [TIME_W-1:0] to);
    logic [TIME_W-1:0] d;
    d = to - from;
    return !d[TIME_W-1];
  endfunction

  function automatic void update_elig(int i, int own_dist, logic [TIME_W-1:0] now);
    if (own_dist >= int'(cfg.snap_thresh)) begin
      trk[i].eligible        = 1'b1;
      trk[i].elig_time       = now;
      trk[i].elig_time_valid = 1'b1;
    end else if (trk[i].elig_time_valid && not_before(trk[i].elig_time, now) &&
                 (now - trk[i].elig_time) >= cfg.eligibility_timeout_us) begin
      trk[i].eligible        = 1'b0;
      trk[i].elig_time_valid = 1'b0;
    end
  endfunction

  function automatic void update_hold(int i, int off, int own_dist, int other_dist,
                                      logic [TIME_W-1:0] now);
    int last_dist;
    bit crossed;
    last_dist = (trk[i].last_off < 0) ? -trk[i].last_off : trk[i].last_off;
    crossed = ((off < 0) != (trk[i].last_off < 0)) &&
              (other_dist <= int'(cfg.cross_limit));
    if (trk[i].eligible && crossed) begin
      trk[i].falling    = 1'b0;
      trk[i].fall_run   = '0;
      trk[i].wave_start = now;
      trk[i].wave_end   = now + cfg.wave_duration_us;
      trk[i].in_hold    = 1'b1;
      trk[i].eligible   = 1'b0;
    end else if (trk[i].in_hold) begin
      if (not_before(trk[i].wave_end, now)) begin
        trk[i].in_hold  = 1'b0;
        trk[i].eligible = 1'b0;
      end else if (!trk[i].falling) begin
        if (own_dist <= last_dist && own_dist >= int'(cfg.fall_floor))
          trk[i].fall_run = trk[i].fall_run + 2'd1;
        else
          trk[i].fall_run = '0;
        if (trk[i].fall_run >= FALL_RUN_LIMIT) begin
          trk[i].falling  = 1'b1;
          trk[i].fall_run = '0;
          trk[i].wave_end = now + (now - trk[i].wave_start) + cfg.wave_buffer_us;
        end
      end
    end
    trk[i].last_off = off;
  endfunction

  function automatic logic [CNT_W-1:0] to_counts(int i, int pos);
    int c, lo, hi, v, r;
    c  = int'(cfg.center) * 16;
    lo = (int'(cfg.center) - int'(cfg.stick_range)) * 16;
    hi = (int'(cfg.center) + int'(cfg.stick_range)) * 16;
    v  = trk[i].in_hold ? c : pos;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    r = (v + 8) >>> 4;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[CNT_W-1:0];
  endfunction

  function automatic stick_result_t filter_sample(bit fr, logic signed [POS_W-1:0] x,
                                                  logic signed [POS_W-1:0] y,
                                                  logic [TIME_W-1:0] now);
    int c, ox, oy, dx, dy;
    stick_result_t res;
    if (fr) begin
      c  = int'(cfg.center) * 16;
      ox = int'(x) - c;
      oy = int'(y) - c;
      dx = (ox < 0) ? -ox : ox;
      dy = (oy < 0) ? -oy : oy;
      update_elig(0, dx, now);
      update_elig(1, dy, now);
      update_hold(0, ox, dx, dy, now);
      update_hold(1, oy, dy, dx, now);
      trk[0].last_out = to_counts(0, int'(x));
      trk[1].last_out = to_counts(1, int'(y));
    end
    res.x  = trk[0].last_out;
    res.y  = trk[1].last_out;
    res.xh = trk[0].in_hold;
    res.yh = trk[1].in_hold;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_sample(input bit fr, input int px, input int py,
                             input logic [TIME_W-1:0] t);
    logic signed [POS_W-1:0] vx, vy;
    int gap;
    vx = px[POS_W-1:0];
    vy = py[POS_W-1:0];
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.fresh   <= fr;
    in_ch.norm_x  <= vx;
    in_ch.norm_y  <= vy;
    in_ch.time_us <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    filtered_q.push_back(filter_sample(fr, vx, vy, t));
    n_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER:        cfg.center                 = data[CNT_W-1:0];
      CFG_STICK_RANGE:   cfg.stick_range            = data[CNT_W-1:0];
      CFG_SNAPBACK_DIST: cfg.snap_thresh            = data[DCFG_W-1:0];
      CFG_CROSSING_DIST: cfg.cross_limit            = data[DCFG_W-1:0];
      CFG_CENTERED_DIST: cfg.fall_floor             = data[DCFG_W-1:0];
      CFG_WAVE_DURATION: cfg.wave_duration_us       = data[US_W-1:0];
      CFG_WAVE_BUFFER:   cfg.wave_buffer_us         = data[US_W-1:0];
      CFG_ELIG_TIMEOUT:  cfg.eligibility_timeout_us = data[US_W-1:0];
      default: ;
    endcase
  endtask

  // dirty puts random bits above the narrow registers' widths
  task automatic load_settings(input cfg_t s, input bit dirty);
    logic [CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = CFG_DATA_W'($urandom);
    if (!dirty) junk = '0;
    write_cfg(CFG_CENTER,        {junk[CFG_DATA_W-1:CNT_W], s.center});
    write_cfg(CFG_STICK_RANGE,   {junk[CFG_DATA_W-1:CNT_W], s.stick_range});
    write_cfg(CFG_SNAPBACK_DIST, {junk[CFG_DATA_W-1:DCFG_W], s.snap_thresh});
    write_cfg(CFG_CROSSING_DIST, {junk[CFG_DATA_W-1:DCFG_W], s.cross_limit});
    write_cfg(CFG_CENTERED_DIST, {junk[CFG_DATA_W-1:DCFG_W], s.fall_floor});
    write_cfg(CFG_WAVE_DURATION, s.wave_duration_us);
    write_cfg(CFG_WAVE_BUFFER,   s.wave_buffer_us);
    write_cfg(CFG_ELIG_TIMEOUT,  s.eligibility_timeout_us);
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern and scoreboard
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int mode, left, cyc;
    mode = 0;
    left = 0;
    cyc  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 160);
      end
      left--;
      cyc++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= (cyc % 4 != 3);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < 100)
      $display("%0t beat %0d: %s got %0d want %0d", $time, n_checked, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin : result_check
    stick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, 0);
      end else begin
        want = filtered_q.pop_front();
        if (out_ch.out_x !== want.x)
          report_mismatch("out_x", 32'(out_ch.out_x), 32'(want.x));
        if (out_ch.out_y !== want.y)
          report_mismatch("out_y", 32'(out_ch.out_y), 32'(want.y));
        if (out_ch.x_held !== want.xh)
          report_mismatch("x_held", 32'(out_ch.x_held), 32'(want.xh));
        if (out_ch.y_held !== want.yh)
          report_mismatch("y_held", 32'(out_ch.y_held), 32'(want.yh));
        if (want.xh || want.yh) n_held++;
      end
      n_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pos_clip(int v);
    if (v > 8191) return 8191;
    if (v < -8192) return -8192;
    return v;
  endfunction

  function automatic int rand_pos();
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  function automatic int near_other();
    int lim, v;
    lim = int'(cfg.cross_limit);
    if ($urandom_range(0, 6) == 0) lim = lim + 3000;
    v = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  task automatic next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) now_us = now_us + $urandom_range(50, 3000);
    else if (r < 97) now_us = now_us + $urandom_range(3000, 250000);
    else now_us = $urandom;
  endtask

  task automatic emit_offsets(input int axis, input int main_off, input int other_off);
    int c, px, py;
    bit fr;
    c  = int'(cfg.center) * 16;
    px = pos_clip(c + ((axis == 0) ? main_off : other_off));
    py = pos_clip(c + ((axis == 0) ? other_off : main_off));
    fr = ($urandom_range(0, 19) != 0);
    next_time();
    send_sample(fr, px, py, now_us);
  endtask

  // wind up past the snapback distance, cross center, then a decaying rebound
  task automatic snap_gesture();
    int axis, sgn, amp, m, n, k, pick;
    axis = $urandom_range(0, 1);
    sgn  = $urandom_range(0, 1) ? 1 : -1;
    amp  = int'(cfg.snap_thresh) + $urandom_range(0, 1500);
    if ($urandom_range(0, 9) == 0) amp = $urandom_range(0, 12000);
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) emit_offsets(axis, sgn * amp * (k + 1) / n, near_other());
    m   = amp * $urandom_range(40, 100) / 100;
    sgn = -sgn;
    n   = $urandom_range(3, 14);
    for (k = 0; k < n; k++) begin
      emit_offsets(axis, sgn * m, near_other());
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        m = m * $urandom_range(75, 100) / 100;
      end else if (pick < 16) begin
        m = m + $urandom_range(1, 200);
      end else if (pick < 18) begin
        sgn = -sgn;
        m   = m * $urandom_range(30, 90) / 100;
      end else begin
        m = $urandom_range(0, int'(cfg.fall_floor) + 10);
      end
    end
  endtask

  task automatic run_traffic(input int count);
    int target, pick, n, k;
    target = n_sent + count;
    while (n_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        snap_gesture();
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          next_time();
          send_sample($urandom_range(0, 3) != 0, rand_pos(), rand_pos(), now_us);
        end
      end else if (pick < 90) begin
        n = $urandom_range(2, 8);
        for (k = 0; k < n; k++)
          emit_offsets(0, int'($urandom_range(0, 200)) - 100,
                       int'($urandom_range(0, 200)) - 100);
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_sample(1'b0, rand_pos(), rand_pos(), $urandom);
      end
    end
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.center                 = CNT_W'($urandom_range(0, 255));
    s.stick_range            = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 255))
                                                           : CNT_W'($urandom_range(0, 128));
    s.snap_thresh            = DCFG_W'($urandom_range(100, 3000));
    s.cross_limit            = DCFG_W'($urandom_range(0, 2000));
    s.fall_floor             = DCFG_W'($urandom_range(0, 300));
    s.wave_duration_us       = US_W'($urandom_range(0, 200000));
    s.wave_buffer_us         = US_W'($urandom_range(0, 20000));
    s.eligibility_timeout_us = US_W'($urandom_range(1000, 300000));
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_stale_and_rounding();
    int c;
    c = int'(cfg.center) * 16;
    send_sample(1'b0, 1234, -77, 32'd500);
    send_sample(1'b1, c, c, 32'd1000);
    send_sample(1'b1, c + 8, c - 8, 32'd2000);
    send_sample(1'b1, 8191, -8192, 32'd3000);
    send_sample(1'b1, c + 7, c - 9, 32'd400000);
  endtask

  task automatic test_snapback_hold();
    int c;
    logic [TIME_W-1:0] t;
    c = int'(cfg.center) * 16;
    t = 32'd1000000;
    send_sample(1'b1, c + 2000, c, t);
    t = t + 1000; send_sample(1'b1, c - 1500, c + 100, t);
    t = t + 1000; send_sample(1'b1, c - 1400, c, t);
    t = t + 1000; send_sample(1'b1, c - 1300, c, t);
    t = t + 1000; send_sample(1'b1, c - 1200, c, t);
    t = t + 1000; send_sample(1'b1, c - 1250, c - 50, t);
    t = t + 10000; send_sample(1'b1, c - 900, c, t);
    t = t + 1000; send_sample(1'b1, c - 1800, c, t);
    // zero offset reads as non-negative, so this is a crossing
    t = t + 1000; send_sample(1'b1, c, c, t);
    send_sample(1'b0, 0, 0, t + 500);
    t = t + 60000; send_sample(1'b1, c + 500, c, t);
  endtask

  task automatic test_time_wrap();
    int c;
    logic [TIME_W-1:0] t;
    c = int'(cfg.center) * 16;
    t = 32'hFFFF_F000;
    send_sample(1'b1, c - 2000, c, t);
    t = t + 32'h1800; send_sample(1'b1, c + 1500, c + 10, t);
    t = t + 1000; send_sample(1'b1, c + 1400, c, t);
    t = t + 60000; send_sample(1'b1, c + 100, c, t);
  endtask

  task automatic test_saturation_extremes();
    cfg_t s;
    s = CFG_RESET;
    s.center      = 8'd0;
    s.stick_range = 8'd255;
    load_settings(s, 1'b0);
    send_sample(1'b1, -8192, 8191, 32'd5000000);
    send_sample(1'b1, -8, 8, 32'd5001000);
    s.center      = 8'd255;
    s.stick_range = 8'd128;
    load_settings(s, 1'b0);
    send_sample(1'b1, 8191, -8192, 32'd5100000);
    send_sample(1'b1, 4080 + 8, 4080 - 8, 32'd5101000);
  endtask

  task automatic test_random_traffic();
    cfg_t s;
    now_us = $urandom;
    load_settings(CFG_RESET, 1'b0);
    run_traffic(300);
    s = CFG_RESET;
    s.snap_thresh            = 13'd300;
    s.cross_limit            = 13'd2000;
    s.fall_floor             = 13'd16;
    s.wave_duration_us       = 20'd3000;
    s.wave_buffer_us         = 20'd500;
    s.eligibility_timeout_us = 20'd5000;
    load_settings(s, 1'b0);
    run_traffic(200);
    s = '0;
    load_settings(s, 1'b0);
    run_traffic(80);
    s = '1;
    load_settings(s, 1'b0);
    run_traffic(80);
    repeat (4) begin
      load_settings(random_settings(), 1'b1);
      run_traffic(135);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_CENTER;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.fresh   = 1'b0;
    in_ch.norm_x  = '0;
    in_ch.norm_y  = '0;
    in_ch.time_us = '0;
    now_us        = '0;
    trk[0]        = '0;
    trk[1]        = '0;
    cfg           = CFG_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_stale_and_rounding();
    test_snapback_hold();
    test_time_wrap();
    test_saturation_extremes();
    test_random_traffic();

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d samples sent, %0d results scored under %0d register settings",
             n_sent, n_checked, n_settings);
    $display("%0d results had an axis held at center, %0d mismatches", n_held, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("run did not drain in time");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
